// File: rtl/md5sh_pkg.sv
// ----------------------------------------------------------------------------
// md5sh_pkg
// Shared types, constants and round functions of the MD5 stream hasher.
// ----------------------------------------------------------------------------
package md5sh_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_ADD
  } state_t;

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    begin
      unique case (r)
        6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    begin
      unique case ({r[5:4], r[1:0]})
        4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
        4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
        4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

  function automatic logic [3:0] word_index(input logic [5:0] r);
    logic [3:0] g;
    begin
      unique case (r[5:4])
        2'd0: g = r[3:0];
        2'd1: g = 4'((r[3:0] << 2) + r[3:0] + 4'd1);
        2'd2: g = 4'((r[3:0] << 1) + r[3:0] + 4'd5);
        default: g = 4'((r[3:0] << 3) - r[3:0]);
      endcase
      return g;
    end
  endfunction

endpackage

// File: rtl/md5_stream_hasher.sv
// A finish gives its digest after its padding writes and one or two 64-round
// passes, and any result stall delays it further.
// Throughput: one byte per cycle while idle; a byte that fills a block holds
// the input while the single round unit compresses it.
// Reset loads the initial chaining words and clears the bit count and control;
// the block memory keeps its contents.
// ----------------------------------------------------------------------------
// md5_stream_hasher
// Byte-serial MD5 engine with the message block held in a 16-word memory.
// ----------------------------------------------------------------------------
module md5_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_finish,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_low,
  output logic [63:0] out_digest_high
);

  logic [31:0] mem [16];
  logic [31:0] rd_r;
  logic        we;
  logic [3:0]  waddr;
  logic [3:0]  raddr;
  logic [31:0] wdata;

  md5sh_pkg::state_t state_r, state_nxt;
  logic [31:0] ha_r, hb_r, hc_r, hd_r;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [63:0] cnt_r;
  logic [31:0] word_r;
  logic [5:0]  pos_r;
  logic [5:0]  rnd_r;
  logic        fin_r;
  logic        last_r;
  logic        out_valid_r;
  logic [63:0] dlo_r, dhi_r;

  logic        take;
  logic        emit;
  logic [31:0] word_new;
  logic [31:0] word_base;
  logic [31:0] word_pad;
  logic [1:0]  pad_lane;
  logic [31:0] fv, sum, rot;
  logic [4:0]  sh;

  assign take = in_valid && !in_stall;
  assign emit = (state_r == md5sh_pkg::ST_ADD) && last_r && !(out_valid_r && out_stall);
  assign in_stall = (state_r != md5sh_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_digest_low = dlo_r;
  assign out_digest_high = dhi_r;

  always_comb begin
    word_new = word_r;
    unique case (pos_r[1:0])
      2'd0: word_new = {24'd0, in_data_byte};
      2'd1: word_new[15:8] = in_data_byte;
      2'd2: word_new[23:16] = in_data_byte;
      default: word_new[31:24] = in_data_byte;
    endcase
  end

  always_comb begin
    word_base = in_byte_valid ? word_new : word_r;
    pad_lane = in_byte_valid ? 2'(pos_r[1:0] + 2'd1) : pos_r[1:0];
    unique case (pad_lane)
      2'd0: word_pad = {24'd0, md5sh_pkg::PAD_BYTE};
      2'd1: word_pad = {16'd0, md5sh_pkg::PAD_BYTE, word_base[7:0]};
      2'd2: word_pad = {8'd0, md5sh_pkg::PAD_BYTE, word_base[15:0]};
      default: word_pad = {md5sh_pkg::PAD_BYTE, word_base[23:0]};
    endcase
  end

  always_comb begin
    unique case (rnd_r[5:4])
      2'd0: fv = (b_r & c_r) | (~b_r & d_r);
      2'd1: fv = (b_r & d_r) | (c_r & ~d_r);
      2'd2: fv = b_r ^ c_r ^ d_r;
      default: fv = c_r ^ (b_r | ~d_r);
    endcase
    sh = md5sh_pkg::rot_amount(rnd_r);
    sum = a_r + fv + md5sh_pkg::round_const(rnd_r) + rd_r;
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      md5sh_pkg::ST_IDLE: begin
        if (take) begin
          if (in_byte_valid && pos_r == 6'd63) state_nxt = md5sh_pkg::ST_LOAD;
          else if (in_finish) state_nxt = md5sh_pkg::ST_PAD;
        end
      end
      md5sh_pkg::ST_PAD: begin
        if (pos_r == 6'd63) state_nxt = md5sh_pkg::ST_LOAD;
        else if (pos_r == 6'(md5sh_pkg::LEN_POS - 6'd1)) state_nxt = md5sh_pkg::ST_LEN;
      end
      md5sh_pkg::ST_LEN: if (pos_r == 6'd63) state_nxt = md5sh_pkg::ST_LOAD;
      md5sh_pkg::ST_LOAD: state_nxt = md5sh_pkg::ST_ROUND;
      md5sh_pkg::ST_ROUND: if (rnd_r == 6'd63) state_nxt = md5sh_pkg::ST_ADD;
      default: begin
        if (last_r) begin
          if (emit) state_nxt = md5sh_pkg::ST_IDLE;
        end else if (fin_r) state_nxt = md5sh_pkg::ST_PAD;
        else state_nxt = md5sh_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = pos_r[5:2];
    wdata = word_new;
    raddr = md5sh_pkg::word_index(rnd_r);
    unique case (state_r)
      md5sh_pkg::ST_IDLE: we = take && in_byte_valid && pos_r[1:0] == 2'd3;
      md5sh_pkg::ST_PAD: begin
        we = pos_r[1:0] == 2'd3 || pos_r == 6'd55;
        wdata = word_r;
      end
      md5sh_pkg::ST_LEN: begin
        we = pos_r == 6'd59 || pos_r == 6'd63;
        wdata = pos_r[2] ? cnt_r[63:32] : cnt_r[31:0];
      end
      md5sh_pkg::ST_LOAD: raddr = 4'd0;
      md5sh_pkg::ST_ROUND: raddr = md5sh_pkg::word_index(6'(rnd_r + 6'd1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= md5sh_pkg::ST_IDLE;
      ha_r <= md5sh_pkg::INIT_A;
      hb_r <= md5sh_pkg::INIT_B;
      hc_r <= md5sh_pkg::INIT_C;
      hd_r <= md5sh_pkg::INIT_D;
      cnt_r <= 64'd0;
      pos_r <= 6'd0;
      rnd_r <= 6'd0;
      fin_r <= 1'b0;
      last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        md5sh_pkg::ST_IDLE: begin
          if (take) begin
            fin_r <= in_finish;
            last_r <= 1'b0;
            if (in_byte_valid) begin
              pos_r <= 6'(pos_r + 6'd1);
              cnt_r <= cnt_r + 64'd8;
            end
            if (in_finish) word_r <= word_pad;
            else if (in_byte_valid) word_r <= word_new;
          end
        end
        md5sh_pkg::ST_PAD: begin
          pos_r <= 6'(pos_r + 6'd1);
          if (pos_r[1:0] == 2'd3) word_r <= 32'd0;
        end
        md5sh_pkg::ST_LEN: begin
          pos_r <= 6'(pos_r + 6'd1);
          if (pos_r == 6'd63) last_r <= 1'b1;
        end
        md5sh_pkg::ST_LOAD: begin
          a_r <= ha_r; b_r <= hb_r; c_r <= hc_r; d_r <= hd_r;
          rnd_r <= 6'd0;
        end
        md5sh_pkg::ST_ROUND: begin
          a_r <= d_r; d_r <= c_r; c_r <= b_r;
          b_r <= b_r + rot;
          rnd_r <= 6'(rnd_r + 6'd1);
        end
        default: begin
          if (last_r) begin
            if (emit) begin
              dlo_r <= {hb_r + b_r, ha_r + a_r};
              dhi_r <= {hd_r + d_r, hc_r + c_r};
              ha_r <= md5sh_pkg::INIT_A;
              hb_r <= md5sh_pkg::INIT_B;
              hc_r <= md5sh_pkg::INIT_C;
              hd_r <= md5sh_pkg::INIT_D;
              cnt_r <= 64'd0;
              pos_r <= 6'd0;
              fin_r <= 1'b0;
              last_r <= 1'b0;
            end
          end else begin
            ha_r <= ha_r + a_r; hb_r <= hb_r + b_r;
            hc_r <= hc_r + c_r; hd_r <= hd_r + d_r;
          end
        end
      endcase
      if (emit) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

endmodule
